>>> design/rida_pkg.sv
// ----------------------------------------------------------------------------
// rida_pkg
// Shared types and constants for the recycling ID allocator.
// ----------------------------------------------------------------------------
package rida_pkg;

   // Sizing of the free stack and of the ID space
   localparam int STACK_DEPTH = 64;
   localparam int ID_WIDTH    = 16;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int FRESH_W     = ID_WIDTH + 1;

   // Port field widths
   localparam int PORT_ID_W   = 16;
   localparam int STATUS_W    = 3;

   // Request kinds
   typedef enum logic {
      MODE_GET     = 1'b0,
      MODE_RECYCLE = 1'b1
   } mode_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_REUSED    = 3'd0,
      ST_FRESH     = 3'd1,
      ST_STORED    = 3'd2,
      ST_DROPPED   = 3'd3,
      ST_EXHAUSTED = 3'd4
   } status_type;

   // Controller states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_POP  = 1'b1
   } state_type;

   // Result handed from the controller to the output stage
   typedef struct packed {
      logic                load;
      logic [ID_WIDTH-1:0] id;
      status_type          status;
   } result_type;

endpackage

>>> design/rida_ram.sv
// ----------------------------------------------------------------------------
// rida_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rida_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rida_ctrl.sv
// ----------------------------------------------------------------------------
// rida_ctrl
// Request decode, stack pointer and fresh counter, free stack access control.
// ----------------------------------------------------------------------------
module rida_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  rida_pkg::mode_type           req_mode,
   input  logic [rida_pkg::ID_WIDTH-1:0] req_id,
   input  logic                         out_free,
   output logic                         ram_wr_en,
   output logic [rida_pkg::ADDR_W-1:0]  ram_wr_addr,
   output logic [rida_pkg::ID_WIDTH-1:0] ram_wr_data,
   output logic                         ram_rd_en,
   output logic [rida_pkg::ADDR_W-1:0]  ram_rd_addr,
   input  logic [rida_pkg::ID_WIDTH-1:0] ram_rd_data,
   output rida_pkg::result_type         result
);

   rida_pkg::state_type               state_ff, state_in;
   logic [rida_pkg::CNT_W-1:0]        count_ff, count_in;
   logic [rida_pkg::FRESH_W-1:0]      fresh_ff, fresh_in;

   logic accept;
   logic stack_full;
   logic stack_empty;
   logic fresh_done;
   logic do_push;
   logic do_pop;
   logic do_fresh;
   logic [rida_pkg::CNT_W-1:0] count_dec;

   // request decode
   assign accept      = req_valid && req_ready;
   assign stack_full  = (count_ff == rida_pkg::CNT_W'(rida_pkg::STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign fresh_done  = fresh_ff[rida_pkg::ID_WIDTH];
   assign do_push     = accept && (req_mode == rida_pkg::MODE_RECYCLE) && !stack_full;
   assign do_pop      = accept && (req_mode == rida_pkg::MODE_GET) && !stack_empty;
   assign do_fresh    = accept && (req_mode == rida_pkg::MODE_GET) && stack_empty
                        && !fresh_done;
   assign count_dec   = count_ff - rida_pkg::CNT_W'(1);

   // free stack port control
   assign ram_wr_en   = do_push;
   assign ram_wr_addr = count_ff[rida_pkg::ADDR_W-1:0];
   assign ram_wr_data = req_id;
   assign ram_rd_en   = do_pop;
   assign ram_rd_addr = count_dec[rida_pkg::ADDR_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rida_pkg::S_IDLE: begin
            if (do_pop) begin
               state_in = rida_pkg::S_POP;
            end
         end
         rida_pkg::S_POP: begin
            if (out_free) begin
               state_in = rida_pkg::S_IDLE;
            end
         end
         default: state_in = rida_pkg::S_IDLE;
      endcase
   end

   // outputs: handshake and result to the output stage
   always_comb begin
      req_ready     = 1'b0;
      result.load   = 1'b0;
      result.id     = '0;
      result.status = rida_pkg::ST_EXHAUSTED;
      unique case (state_ff)
         rida_pkg::S_IDLE: begin
            req_ready = out_free;
            if (req_mode == rida_pkg::MODE_RECYCLE) begin
               result.load   = accept;
               result.status = stack_full ? rida_pkg::ST_DROPPED : rida_pkg::ST_STORED;
            end else if (stack_empty) begin
               result.load = accept;
               if (!fresh_done) begin
                  result.id     = fresh_ff[rida_pkg::ID_WIDTH-1:0];
                  result.status = rida_pkg::ST_FRESH;
               end
            end
         end
         rida_pkg::S_POP: begin
            result.load   = out_free;
            result.id     = ram_rd_data;
            result.status = rida_pkg::ST_REUSED;
         end
         default: ;
      endcase
   end

   // stack pointer and fresh counter
   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + rida_pkg::CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_dec;
      end
      fresh_in = do_fresh ? fresh_ff + rida_pkg::FRESH_W'(1) : fresh_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rida_pkg::S_IDLE;
         count_ff <= '0;
         fresh_ff <= rida_pkg::FRESH_W'(1);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
      end
   end

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rida_pkg::CNT_W'(rida_pkg::STACK_DEPTH))
      else $error("stack count beyond depth");

   a_fresh_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff != '0 && (!fresh_ff[rida_pkg::ID_WIDTH] || fresh_ff[rida_pkg::ID_WIDTH-1:0] == '0))
      else $error("fresh counter out of range");

   a_no_accept_in_pop: assert property (@(posedge clock) disable iff (reset)
      state_ff == rida_pkg::S_POP |-> !req_ready)
      else $error("request taken while a pop is pending");

   a_pop_lowers_count: assert property (@(posedge clock) disable iff (reset)
      do_pop |=> count_ff == $past(count_dec))
      else $error("pop did not lower the stack count");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      result.load |-> out_free)
      else $error("result loaded into a busy output stage");

endmodule

>>> design/rida_out.sv
// ----------------------------------------------------------------------------
// rida_out
// Output register stage for the result channel.
// ----------------------------------------------------------------------------
module rida_out (
   input  logic                                clock,
   input  logic                                reset,
   input  rida_pkg::result_type                result,
   output logic                                out_free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rida_pkg::PORT_ID_W-1:0]      rsp_tdata,
   output logic [rida_pkg::STATUS_W-1:0]       rsp_tuser
);

   logic                           valid_ff, valid_in;
   logic [rida_pkg::PORT_ID_W-1:0] id_ff, id_in;
   rida_pkg::status_type           status_ff, status_in;
   logic [31:0]                    id_wide;

   // room for a new result at the next edge
   assign out_free = !valid_ff || rsp_tready;
   assign id_wide  = 32'(result.id);

   always_comb begin
      valid_in  = valid_ff && !rsp_tready;
      id_in     = id_ff;
      status_in = status_ff;
      if (result.load) begin
         valid_in  = 1'b1;
         id_in     = id_wide[rida_pkg::PORT_ID_W-1:0];
         status_in = result.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = id_ff;
   assign rsp_tuser  = status_ff;

endmodule

>>> design/recycling_id_allocator_top.sv
// ----------------------------------------------------------------------------
// recycling_id_allocator_top
// Tag allocator: hands out IDs from a LIFO free stack or a fresh counter.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_): tuser selects get (0) or recycle (1); tdata holds
//   the ID to recycle. Every request transaction yields one response.
//   Response channel (rsp_): tdata is the granted ID (0 when none), tuser the
//   status: reused, fresh, stored, dropped on a full stack, IDs exhausted.
//   Fresh IDs start at 1; ID 0 is never generated.
// Response path and throughput:
//   Recycles and gets served from the fresh counter respond in the cycle after
//   acceptance and may be issued every cycle while the output stage has room.
//   A get that pops the free stack goes through the registered stack RAM read
//   and then the output register, and blocks new requests until it is loaded.
// Reset:
//   Synchronous, active high. Empties the stack and sets the fresh counter
//   to 1; the stack RAM itself is not cleared and needs no clearing pass.
// Back-pressure:
//   A single output register holds the response; a new request is taken
//   while it is empty or draining, and held off while it is full and rsp_tready is low.
// ----------------------------------------------------------------------------
module recycling_id_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] recycle_id
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] granted_id
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   logic                          out_free;
   rida_pkg::result_type          result;
   logic                          ram_wr_en;
   logic [rida_pkg::ADDR_W-1:0]   ram_wr_addr;
   logic [rida_pkg::ID_WIDTH-1:0] ram_wr_data;
   logic                          ram_rd_en;
   logic [rida_pkg::ADDR_W-1:0]   ram_rd_addr;
   logic [rida_pkg::ID_WIDTH-1:0] ram_rd_data;
   logic [31:0]                   req_id_wide;
   rida_pkg::mode_type            req_mode;

   // keep only the ID bits of the recycled value
   assign req_id_wide = 32'(req_tdata);
   assign req_mode    = rida_pkg::mode_type'(req_tuser);

   rida_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_mode    (req_mode),
      .req_id      (req_id_wide[rida_pkg::ID_WIDTH-1:0]),
      .out_free    (out_free),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .result      (result)
   );

   // free stack storage
   rida_ram #(
      .WIDTH (rida_pkg::ID_WIDTH),
      .DEPTH (rida_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rida_out u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
